[rtl/ueds_pkg.sv]
// shared constants and types for the ultrasonic echo distance service unit
`default_nettype none
package ueds_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_SERVICE_PERIOD = 2'd0,
		CFG_MIN_DISTANCE   = 2'd1,
		CFG_MAX_DISTANCE   = 2'd2
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 2;

	// register reset values
	localparam logic [7:0]  PERIOD_RESET   = 8'd10;
	localparam logic [15:0] MIN_DIST_RESET = 16'd20;
	localparam logic [15:0] MAX_DIST_RESET = 16'd4000;

	// capture status layout
	localparam int unsigned ECHO_DONE_BIT = 7;
	localparam int unsigned ECHO_OVF_W    = 6;

	// echo time in us: overflow count and 16-bit timer count side by side
	localparam int unsigned ECHO_US_W = ECHO_OVF_W + 16;
	// us * 17, the 170/1000 factor reduced to 17/100
	localparam int unsigned SCALED_W  = ECHO_US_W + 5;
	localparam int unsigned SOUND_NUM_SHIFT = 4;

	// divide by 100 as multiply by ceil(2^33 / 100), exact for inputs below 2^30
	localparam int unsigned DIV_SHIFT = 33;
	localparam int unsigned RECIP_W   = 27;
	localparam logic [RECIP_W-1:0] DIV100_RECIP = 27'd85899346;
	localparam int unsigned PROD_W    = SCALED_W + RECIP_W;

	// distance in mm before range check, max about 713 000
	localparam int unsigned MM_W = 20;

	localparam logic [7:0] MISS_LIMIT = 8'd255;

endpackage
`default_nettype wire

[rtl/ultrasonic_echo_distance_service_unit.sv]
// top level of the ultrasonic echo distance service unit
//
// each input request is one tick carrying the echo capture status and timer
// count; a tick counter fires a measurement service once every service_period
// ticks (every tick when service_period is zero), and only service ticks produce a result request
// input channel: in_valid / in_stall, accepted when valid and not stalled
// output channel: out_valid / out_stall, taken when valid and not stalled
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; ready is
// always high, unknown indexes are dropped
// throughput: one tick per cycle while in_stall is low
// a service tick runs through three register stages (input register,
// reciprocal multiply register, result register); non-service ticks only
// bump the counter
// each stage moves when the one after it is empty or draining, so a stalled
// result only holds back the input once all three stages are full
// reset: counters and held distance cleared, registers back to period 10,
// range 20..4000 mm, pipeline emptied
`default_nettype none
module ultrasonic_echo_distance_service_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// tick requests
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      capture_status,
	input  wire logic [15:0]                     capture_count,
	// service results
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [15:0]                          echo_range_mm,
	output logic                                 sample_valid,
	output logic [7:0]                           misses,
	output logic [31:0]                          sample_number,
	output logic                                 clear_capture,
	// configuration writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ueds_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [15:0]                     cfg_data
);

	// configuration registers
	logic [7:0]  period_q;
	logic [15:0] min_dist_q;
	logic [15:0] max_dist_q;

	// running state
	logic [7:0]  tick_q;
	logic [31:0] samp_q;
	logic [7:0]  miss_q;
	logic [15:0] held_q;

	// stage 1: captured service tick
	logic                              v_s1;
	logic [7:0]                        status_s1;
	logic [15:0]                       count_s1;

	// stage 2: distance after the reciprocal multiply
	logic                              v_s2;
	logic                              done_s2;
	logic                              clr_s2;
	logic [ueds_pkg::MM_W-1:0]         mm_s2;

	// result register
	logic                              out_v_q;
	logic [15:0]                       dist_q;
	logic                              svalid_q;
	logic [7:0]                        misses_q;
	logic [31:0]                       snum_q;
	logic                              clr_q;

	// stage enables, each stage moves when the next has room
	logic en_out;
	logic en_s2;
	logic en_s1;
	logic in_acc;

	assign en_out = !out_v_q || !out_stall;
	assign en_s2  = !v_s2 || en_out;
	assign en_s1  = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign in_acc   = in_valid && en_s1;

	// service decision, 9 bits so the tick increment never wraps before the compare
	logic [8:0] tick_next;
	logic       fire;

	assign tick_next = {1'b0, tick_q} + 9'd1;
	assign fire      = tick_next >= {1'b0, period_q};

	// configuration port never pushes back
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= ueds_pkg::PERIOD_RESET;
			min_dist_q <= ueds_pkg::MIN_DIST_RESET;
			max_dist_q <= ueds_pkg::MAX_DIST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ueds_pkg::CFG_SERVICE_PERIOD: period_q   <= cfg_data[7:0];
				ueds_pkg::CFG_MIN_DISTANCE:   min_dist_q <= cfg_data;
				ueds_pkg::CFG_MAX_DISTANCE:   max_dist_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick counter, wraps to zero on every service
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (in_acc) begin
			tick_q <= fire ? 8'd0 : tick_next[7:0];
		end
	end

	// stage 1: only service ticks go further
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid && fire) begin
			status_s1 <= capture_status;
			count_s1  <= capture_count;
		end
	end

	// echo time in us: overflow count times 65536 is just a concatenation
	logic [ueds_pkg::ECHO_US_W-1:0] echo_us;
	logic [ueds_pkg::SCALED_W-1:0]  scaled;
	logic [ueds_pkg::PROD_W-1:0]    prod;

	assign echo_us = {status_s1[ueds_pkg::ECHO_OVF_W-1:0], count_s1};
	// us * 17 by shift and add
	assign scaled  = ueds_pkg::SCALED_W'({echo_us, ueds_pkg::SOUND_NUM_SHIFT'(0)})
		+ ueds_pkg::SCALED_W'(echo_us);
	// floor(scaled / 100)
	assign prod    = ueds_pkg::PROD_W'(scaled) * ueds_pkg::PROD_W'(ueds_pkg::DIV100_RECIP);

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			done_s2 <= status_s1[ueds_pkg::ECHO_DONE_BIT];
			clr_s2  <= status_s1 != 8'd0;
			mm_s2   <= prod[ueds_pkg::DIV_SHIFT +: ueds_pkg::MM_W];
		end
	end

	// range check and state update
	logic        in_range;
	logic [7:0]  miss_next;
	logic [15:0] held_next;
	logic [31:0] samp_next;

	assign in_range = done_s2
		&& (mm_s2 >= ueds_pkg::MM_W'(min_dist_q))
		&& (mm_s2 <= ueds_pkg::MM_W'(max_dist_q));

	always_comb begin
		if (in_range) begin
			miss_next = 8'd0;
		end else if (miss_q < ueds_pkg::MISS_LIMIT) begin
			miss_next = miss_q + 8'd1;
		end else begin
			miss_next = miss_q;
		end
		held_next = in_range ? mm_s2[15:0] : held_q;
		samp_next = samp_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			miss_q  <= '0;
			held_q  <= '0;
			samp_q  <= '0;
		end else if (en_out) begin
			out_v_q <= v_s2;
			if (v_s2) begin
				miss_q <= miss_next;
				held_q <= held_next;
				samp_q <= samp_next;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			dist_q   <= held_next;
			svalid_q <= in_range;
			misses_q <= miss_next;
			snum_q   <= samp_next;
			clr_q    <= clr_s2;
		end
	end

	assign out_valid     = out_v_q;
	assign echo_range_mm = dist_q;
	assign sample_valid  = svalid_q;
	assign misses        = misses_q;
	assign sample_number = snum_q;
	assign clear_capture = clr_q;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the ultrasonic echo distance service unit
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// the two-bit index space has one slot with no register behind it
	localparam logic [ueds_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
	// cycles to let a request drain through the three stages before a register write
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic [7:0]  status;
		logic [15:0] count;
	} echo_tick_t;

	typedef struct packed {
		logic [15:0] distance;
		logic        in_range;
		logic [7:0]  miss_run;
		logic [31:0] number;
		logic        clear;
	} service_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  capture_status = '0;
	logic [15:0] capture_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] echo_range_mm;
	logic        sample_valid;
	logic [7:0]  misses;
	logic [31:0] sample_number;
	logic        clear_capture;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [ueds_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// ticks waiting to be driven, and services the unit still owes us
	echo_tick_t      pending_ticks[$];
	service_result_t expected_services[$];

	// idling percentages for the current phase
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  tick_taken = 1'b0;
	int  mismatches = 0;

	// predictor state: registers and counters of the service unit
	logic [7:0]  period_reg = ueds_pkg::PERIOD_RESET;
	logic [15:0] min_mm_reg = ueds_pkg::MIN_DIST_RESET;
	logic [15:0] max_mm_reg = ueds_pkg::MAX_DIST_RESET;
	logic [7:0]  tick_count = '0;
	logic [31:0] service_count = '0;
	logic [7:0]  miss_run = '0;
	logic [15:0] held_mm = '0;

	ultrasonic_echo_distance_service_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.capture_status(capture_status),
		.capture_count (capture_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.echo_range_mm (echo_range_mm),
		.sample_valid  (sample_valid),
		.misses        (misses),
		.sample_number (sample_number),
		.clear_capture (clear_capture),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// one tick into the predictor; a service tick queues the result it owes
	task automatic predict_tick(input logic [7:0] sta, input logic [15:0] cnt);
		logic [31:0]     next_count;
		logic [31:0]     echo_us;
		logic [31:0]     echo_mm;
		logic            ok;
		service_result_t res;
		next_count = {24'd0, tick_count} + 32'd1;
		if (next_count < {24'd0, period_reg}) begin
			tick_count = next_count[7:0];
			return;
		end
		tick_count = '0;
		ok = 1'b0;
		echo_mm = '0;
		// bit 6 plays no part in the echo time
		if (sta[ueds_pkg::ECHO_DONE_BIT]) begin
			echo_us = {10'd0, sta[ueds_pkg::ECHO_OVF_W-1:0], cnt};
			echo_mm = echo_us * 32'd170 / 32'd1000;
			ok = (echo_mm >= {16'd0, min_mm_reg}) && (echo_mm <= {16'd0, max_mm_reg});
		end
		if (ok) begin
			miss_run = '0;
			held_mm = echo_mm[15:0];
		end else if (miss_run != ueds_pkg::MISS_LIMIT) begin
			miss_run = miss_run + 8'd1;
		end
		service_count = service_count + 32'd1;
		res.distance = held_mm;
		res.in_range = ok;
		res.miss_run = miss_run;
		res.number = service_count;
		res.clear = (sta != 8'd0);
		expected_services.push_back(res);
	endtask

	task automatic report_field(input string field, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			$display("%0t: service result field %s got 0x%0h, expected 0x%0h",
				$realtime, field, got, want);
			mismatches++;
		end
	endtask

	task automatic report_unexpected();
		$display("%0t: service result with nothing expected", $realtime);
		mismatches++;
	endtask

	// monitor: take requests into the predictor, check results in order
	always @(posedge clk) begin
		service_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_services.size() == 0) begin
				report_unexpected();
			end else begin
				want = expected_services.pop_front();
				report_field("echo_range_mm", {16'd0, echo_range_mm}, {16'd0, want.distance});
				report_field("sample_valid", {31'd0, sample_valid}, {31'd0, want.in_range});
				report_field("misses", {24'd0, misses}, {24'd0, want.miss_run});
				report_field("sample_number", sample_number, want.number);
				report_field("clear_capture", {31'd0, clear_capture}, {31'd0, want.clear});
			end
		end
		tick_taken = arst_n && in_valid && !in_stall;
		if (tick_taken)
			predict_tick(capture_status, capture_count);
	end

	// driver: a request stays up until taken, then the next one or a gap follows
	always @(negedge clk) begin
		echo_tick_t tick_next;
		if (arst_n && (!in_valid || tick_taken)) begin
			if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				tick_next = pending_ticks.pop_front();
				in_valid <= 1'b1;
				capture_status <= tick_next.status;
				capture_count <= tick_next.count;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// mostly completed echoes of plausible length, the rest anything at all
	function automatic echo_tick_t random_tick();
		echo_tick_t t;
		int         pick;
		pick = $urandom_range(9);
		t.count = 16'($urandom_range(65535));
		if (pick <= 5)
			t.status = {1'b1, 1'($urandom_range(1)), 5'd0, 1'($urandom_range(1))};
		else if (pick == 6)
			t.status = 8'($urandom_range(255));
		else if (pick == 7)
			t.status = 8'd0;
		else if (pick == 8)
			t.status = {1'b1, 7'($urandom_range(127))};
		else
			t.status = {1'b0, 7'($urandom_range(127))};
		return t;
	endfunction

	task automatic queue_random_ticks(input int n);
		repeat (n) pending_ticks.push_back(random_tick());
	endtask

	task automatic queue_tick(input logic [7:0] sta, input logic [15:0] cnt);
		echo_tick_t t;
		t.status = sta;
		t.count = cnt;
		pending_ticks.push_back(t);
	endtask

	// wait for every request taken and every owed result returned
	task automatic wait_drained();
		while (pending_ticks.size() != 0 || in_valid || expected_services.size() != 0)
			@(posedge clk);
	endtask

	// drain, then give non-service ticks time to leave the pipeline
	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ueds_pkg::CFG_INDEX_W-1:0] idx,
		input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			ueds_pkg::CFG_SERVICE_PERIOD: period_reg = data[7:0];
			ueds_pkg::CFG_MIN_DISTANCE:   min_mm_reg = data;
			ueds_pkg::CFG_MAX_DISTANCE:   max_mm_reg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers at their reset values: ten ticks make one service
		set_idling(0, 0);
		repeat (9) queue_tick(8'h00, 16'h0000);
		queue_tick(8'h80, 16'd1000);
		// count left part way, then the period is cut below it
		repeat (7) queue_tick(8'hFF, 16'hFFFF);
		settle();
		write_reg(ueds_pkg::CFG_SERVICE_PERIOD, 16'd3);
		queue_tick(8'h80, 16'h1234);
		settle();

		// every tick a service, widest range; upper data bits of the period dropped
		write_reg(ueds_pkg::CFG_SERVICE_PERIOD, 16'hAB01);
		write_reg(ueds_pkg::CFG_MIN_DISTANCE, 16'h0000);
		write_reg(ueds_pkg::CFG_MAX_DISTANCE, 16'hFFFF);
		// a write to the slot with no register must change nothing
		write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
		queue_tick(8'h00, 16'h0000);
		queue_tick(8'hFF, 16'hFFFF);   // far beyond 16-bit millimetres
		queue_tick(8'h80, 16'h0000);   // zero distance at a zero minimum
		queue_tick(8'h80, 16'hFFFF);
		queue_tick(8'hC0, 16'd5000);   // bit 6 set alongside done
		queue_tick(8'h40, 16'd5000);   // echo not complete
		queue_tick(8'h01, 16'h0000);
		queue_tick(8'h85, 16'd57820);  // exactly 65535 mm
		queue_tick(8'h85, 16'd57826);  // one past 65535 mm
		queue_tick(8'h86, 16'h0000);
		settle();

		// random, back to back
		queue_random_ticks(100);
		settle();

		// random range, sender mostly idle
		write_reg(ueds_pkg::CFG_MIN_DISTANCE, 16'($urandom_range(3000)));
		write_reg(ueds_pkg::CFG_MAX_DISTANCE, min_mm_reg + 16'($urandom_range(20000)));
		set_idling(69, 0);
		queue_random_ticks(100);
		settle();

		// period zero with minimum above maximum: misses run into saturation
		write_reg(ueds_pkg::CFG_SERVICE_PERIOD, 16'h0000);
		write_reg(ueds_pkg::CFG_MIN_DISTANCE, 16'd30000);
		write_reg(ueds_pkg::CFG_MAX_DISTANCE, 16'd100);
		set_idling(0, 69);
		queue_random_ticks(270);
		settle();

		// a short random period, both sides idling, with a full pause midway
		write_reg(ueds_pkg::CFG_SERVICE_PERIOD, 16'($urandom_range(6, 2)));
		write_reg(ueds_pkg::CFG_MIN_DISTANCE, 16'd20);
		write_reg(ueds_pkg::CFG_MAX_DISTANCE, 16'd4000);
		set_idling(15, 15);
		queue_random_ticks(75);
		wait_drained();
		queue_random_ticks(75);
		settle();

		// longest period, left part way into the next period
		write_reg(ueds_pkg::CFG_SERVICE_PERIOD, 16'h00FF);
		set_idling(69, 0);
		queue_random_ticks(260);
		settle();

		if (mismatches == 0)
			$display("ultrasonic_echo_distance_service_unit regression: pass");
		else
			$display("ultrasonic_echo_distance_service_unit regression: fail");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("ultrasonic_echo_distance_service_unit regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
